// ----- hdl/ps2dl_pkg.sv -----
package ps2dl_pkg;

  typedef enum logic [1:0] {
    LS_IDLE    = 2'd0,
    LS_SEND    = 2'd1,
    LS_REQUEST = 2'd2,
    LS_RECEIVE = 2'd3
  } link_state_e;

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_DATA     = 3'd1,
    PH_PARITY   = 3'd2,
    PH_STOP     = 3'd3,
    PH_ACK      = 3'd4,
    PH_UNACK    = 3'd5,
    PH_FINISHED = 3'd6
  } frame_phase_e;

  typedef enum logic [2:0] {
    OP_RISE = 3'd0,
    OP_FALL = 3'd1,
    OP_DATA = 3'd2,
    OP_SEND = 3'd3,
    OP_READ = 3'd4
  } op_e;

  localparam int unsigned OpW    = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 4;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic             clk_pin;
    logic             data_pin;
    logic [ByteW-1:0] tx_byte;
  } item_t;

  typedef struct packed {
    logic             clk_drive;
    logic             data_drive;
    logic             link_idle;
    logic             tx_accepted;
    logic             rx_valid;
    logic [ByteW-1:0] rx_byte;
    logic             rx_dropped;
  } result_t;

endpackage

// ----- hdl/ps2dl_item_if.sv -----
interface ps2dl_item_if;
  logic                         valid;
  logic                         ready;
  logic [ps2dl_pkg::OpW-1:0]    op;
  logic                         clk_pin;
  logic                         data_pin;
  logic [ps2dl_pkg::ByteW-1:0]  tx_byte;

  modport source (output valid, output op, output clk_pin, output data_pin,
                  output tx_byte, input ready);
  modport sink   (input valid, input op, input clk_pin, input data_pin,
                  input tx_byte, output ready);
endinterface

// ----- hdl/ps2dl_result_if.sv -----
interface ps2dl_result_if;
  logic                         valid;
  logic                         ready;
  logic                         clk_drive;
  logic                         data_drive;
  logic                         link_idle;
  logic                         tx_accepted;
  logic                         rx_valid;
  logic [ps2dl_pkg::ByteW-1:0]  rx_byte;
  logic                         rx_dropped;

  modport source (output valid, output clk_drive, output data_drive, output link_idle,
                  output tx_accepted, output rx_valid, output rx_byte,
                  output rx_dropped, input ready);
  modport sink   (input valid, input clk_drive, input data_drive, input link_idle,
                  input tx_accepted, input rx_valid, input rx_byte,
                  input rx_dropped, output ready);
endinterface

// ----- hdl/ps2dl_ram.sv -----
module ps2dl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/ps2_device_link_engine_top.sv -----
// Device side of a PS/2 link; the device generates the bus clock itself.
// item_i (sink) takes one event per beat: clock-rise, clock-fall or data
// tick from the bit timer with the sampled clock/data pins, a send request
// carrying tx_byte, or a read of the receive ring. result_o (source) gives
// exactly one beat per item: clock and data drive levels, link idle flag,
// send accepted, popped byte with rx_valid, and the ring-overflow flag.
// Result valid rises as the item moves from the input register through the
// step rule into the result register. With result_o.ready high, one item per
// cycle is sustained, set by the single step stage between the input
// register and the result register. Ring reads come from a registered
// RAM that is prefetched at the tail pointer, so pops also run every cycle.
// Reset puts the link idle with both lines released, clears the ring
// pointers and any pending send; ring contents are not cleared.
// When result_o.ready is low the result register holds, the input register
// fills and item_i.ready drops until the result beat is taken.
module ps2_device_link_engine_top #(
  parameter int unsigned RX_DEPTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ps2dl_item_if.sink            item_i,
  ps2dl_result_if.source        result_o
);

  localparam int unsigned AW = $clog2(RX_DEPTH);
  localparam int unsigned BW = ps2dl_pkg::ByteW;
  localparam int unsigned CW = ps2dl_pkg::CountW;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    ring_next = (p == AW'(RX_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  ps2dl_pkg::item_t   in_q;
  logic               in_valid_q;
  ps2dl_pkg::result_t res_q, res_d;
  logic               res_valid_q;
  logic               adv;

  ps2dl_pkg::link_state_e  link_q, link_d;
  ps2dl_pkg::frame_phase_e phase_q, phase_d;
  logic                    pend_q, pend_d;
  logic [BW-1:0]           txsh_q, txsh_d;
  logic [CW-1:0]           txcnt_q, txcnt_d;
  logic [BW-1:0]           rxsh_q, rxsh_d;
  logic [CW-1:0]           rxcnt_q, rxcnt_d;
  logic                    par_q, par_d;
  logic                    clkl_q, clkl_d;
  logic                    datl_q, datl_d;
  logic [AW-1:0]           head_q, head_d;
  logic [AW-1:0]           tail_q, tail_d;

  logic          ram_wr;
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [BW-1:0] ram_rdata;
  logic          byp_q;
  logic [BW-1:0] byp_data_q;
  logic [BW-1:0] tail_data;

  assign adv          = in_valid_q && (!res_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (item_i.ready) begin
        in_valid_q <= item_i.valid;
      end
      if (adv) begin
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      in_q.op       <= item_i.op;
      in_q.clk_pin  <= item_i.clk_pin;
      in_q.data_pin <= item_i.data_pin;
      in_q.tx_byte  <= item_i.tx_byte;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  // step rule
  always_comb begin
    logic cell_bit;
    cell_bit = 1'b0;
    link_d   = link_q;
    phase_d  = phase_q;
    pend_d   = pend_q;
    txsh_d   = txsh_q;
    txcnt_d  = txcnt_q;
    rxsh_d   = rxsh_q;
    rxcnt_d  = rxcnt_q;
    par_d    = par_q;
    clkl_d   = clkl_q;
    datl_d   = datl_q;
    head_d   = head_q;
    tail_d   = tail_q;
    ram_wr   = 1'b0;
    res_d    = '0;

    unique case (ps2dl_pkg::op_e'(in_q.op))
      ps2dl_pkg::OP_RISE: begin
        if (link_d == ps2dl_pkg::LS_IDLE) begin
          if (!in_q.clk_pin) begin
            link_d = ps2dl_pkg::LS_REQUEST;
          end
        end else if (link_d == ps2dl_pkg::LS_REQUEST) begin
          if (in_q.clk_pin) begin
            if (!in_q.data_pin) begin
              link_d  = ps2dl_pkg::LS_RECEIVE;
              phase_d = ps2dl_pkg::PH_START;
            end else begin
              link_d = ps2dl_pkg::LS_IDLE;
            end
          end
        end
        if (link_d == ps2dl_pkg::LS_SEND || link_d == ps2dl_pkg::LS_RECEIVE) begin
          clkl_d = 1'b1;
        end
        if (link_d == ps2dl_pkg::LS_SEND && phase_d == ps2dl_pkg::PH_FINISHED) begin
          link_d = ps2dl_pkg::LS_IDLE;
          pend_d = 1'b0;
        end
        if (link_d == ps2dl_pkg::LS_IDLE && pend_d) begin
          link_d  = ps2dl_pkg::LS_SEND;
          phase_d = ps2dl_pkg::PH_START;
        end
      end
      ps2dl_pkg::OP_FALL: begin
        if (link_q == ps2dl_pkg::LS_SEND || link_q == ps2dl_pkg::LS_RECEIVE) begin
          clkl_d = 1'b0;
        end
        if (link_q == ps2dl_pkg::LS_RECEIVE && phase_q == ps2dl_pkg::PH_FINISHED) begin
          clkl_d = 1'b1;
          datl_d = 1'b1;
          link_d = ps2dl_pkg::LS_IDLE;
        end
      end
      ps2dl_pkg::OP_DATA: begin
        if (link_q == ps2dl_pkg::LS_SEND || link_q == ps2dl_pkg::LS_RECEIVE) begin
          if (!in_q.clk_pin) begin
            // host holds clock low: abort
            datl_d = 1'b1;
            link_d = ps2dl_pkg::LS_IDLE;
          end else if (link_q == ps2dl_pkg::LS_SEND) begin
            unique case (phase_q)
              ps2dl_pkg::PH_START: begin
                txcnt_d = '0;
                par_d   = 1'b0;
                datl_d  = 1'b0;
                phase_d = ps2dl_pkg::PH_DATA;
              end
              ps2dl_pkg::PH_DATA: begin
                cell_bit = txsh_q[txcnt_q[2:0]];
                txcnt_d  = txcnt_q + CW'(1);
                par_d    = par_q ^ cell_bit;
                datl_d   = cell_bit;
                if (txcnt_d > CW'(7)) begin
                  par_d   = ~par_d;
                  phase_d = ps2dl_pkg::PH_PARITY;
                end
              end
              ps2dl_pkg::PH_PARITY: begin
                datl_d  = par_q;
                phase_d = ps2dl_pkg::PH_STOP;
              end
              ps2dl_pkg::PH_STOP: begin
                datl_d  = 1'b1;
                phase_d = ps2dl_pkg::PH_FINISHED;
              end
              default: begin
                datl_d = 1'b1;
              end
            endcase
          end else begin
            cell_bit = in_q.data_pin;
            unique case (phase_q)
              ps2dl_pkg::PH_START: begin
                rxcnt_d = '0;
                par_d   = 1'b0;
                if (!cell_bit) begin
                  rxsh_d  = '0;
                  phase_d = ps2dl_pkg::PH_DATA;
                end
              end
              ps2dl_pkg::PH_DATA: begin
                rxsh_d[rxcnt_q[2:0]] = rxsh_q[rxcnt_q[2:0]] | cell_bit;
                rxcnt_d = rxcnt_q + CW'(1);
                par_d   = par_q ^ cell_bit;
                if (rxcnt_d > CW'(7)) begin
                  par_d   = ~par_d;
                  phase_d = ps2dl_pkg::PH_PARITY;
                end
              end
              ps2dl_pkg::PH_PARITY: begin
                phase_d = ps2dl_pkg::PH_STOP;
              end
              ps2dl_pkg::PH_STOP: begin
                phase_d = ps2dl_pkg::PH_ACK;
              end
              ps2dl_pkg::PH_ACK: begin
                datl_d  = 1'b0;
                phase_d = ps2dl_pkg::PH_UNACK;
              end
              ps2dl_pkg::PH_UNACK: begin
                datl_d = 1'b1;
                ram_wr = 1'b1;
                if (ring_next(head_q) != tail_q) begin
                  head_d = ring_next(head_q);
                end else begin
                  res_d.rx_dropped = 1'b1;
                end
                phase_d = ps2dl_pkg::PH_FINISHED;
              end
              default: begin
              end
            endcase
          end
        end
      end
      ps2dl_pkg::OP_SEND: begin
        if (link_q == ps2dl_pkg::LS_IDLE && !pend_q) begin
          txsh_d            = in_q.tx_byte;
          pend_d            = 1'b1;
          res_d.tx_accepted = 1'b1;
        end
      end
      ps2dl_pkg::OP_READ: begin
        if (link_q == ps2dl_pkg::LS_IDLE && head_q != tail_q) begin
          res_d.rx_byte  = tail_data;
          res_d.rx_valid = 1'b1;
          tail_d         = ring_next(tail_q);
        end
      end
      default: begin
      end
    endcase

    res_d.clk_drive  = clkl_d;
    res_d.data_drive = datl_d;
    res_d.link_idle  = (link_d == ps2dl_pkg::LS_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q  <= ps2dl_pkg::LS_IDLE;
      phase_q <= ps2dl_pkg::PH_START;
      pend_q  <= 1'b0;
      txsh_q  <= '0;
      txcnt_q <= '0;
      rxsh_q  <= '0;
      rxcnt_q <= '0;
      par_q   <= 1'b0;
      clkl_q  <= 1'b1;
      datl_q  <= 1'b1;
      head_q  <= '0;
      tail_q  <= '0;
    end else if (adv) begin
      link_q  <= link_d;
      phase_q <= phase_d;
      pend_q  <= pend_d;
      txsh_q  <= txsh_d;
      txcnt_q <= txcnt_d;
      rxsh_q  <= rxsh_d;
      rxcnt_q <= rxcnt_d;
      par_q   <= par_d;
      clkl_q  <= clkl_d;
      datl_q  <= datl_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
    end
  end

  // ring storage, read port prefetches the next tail entry
  assign ram_we    = adv && ram_wr;
  assign ram_raddr = adv ? tail_d : tail_q;

  ps2dl_ram #(
    .WIDTH (BW),
    .DEPTH (RX_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_q),
    .wdata_i (rxsh_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // write/read collision on the same entry: forward the written byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= ram_we && (head_q == ram_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= rxsh_q;
  end

  assign tail_data = byp_q ? byp_data_q : ram_rdata;

  assign result_o.valid       = res_valid_q;
  assign result_o.clk_drive   = res_q.clk_drive;
  assign result_o.data_drive  = res_q.data_drive;
  assign result_o.link_idle   = res_q.link_idle;
  assign result_o.tx_accepted = res_q.tx_accepted;
  assign result_o.rx_valid    = res_q.rx_valid;
  assign result_o.rx_byte     = res_q.rx_byte;
  assign result_o.rx_dropped  = res_q.rx_dropped;

  a_send_has_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (link_q == ps2dl_pkg::LS_SEND) |-> pend_q)
    else $error("send in progress without a pending byte");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.rx_valid) |-> res_q.link_idle)
    else $error("byte popped while link busy");

  a_drop_in_receive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.rx_dropped) |-> !res_q.link_idle && !res_q.rx_valid)
    else $error("overflow flagged outside a receive frame");

  a_one_sw_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> !(res_q.tx_accepted && res_q.rx_valid))
    else $error("send and read reported in one beat");

  a_tail_moves_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_q != $past(tail_q)) |-> (res_valid_q && res_q.rx_valid))
    else $error("ring tail moved without a pop");

endmodule
